@@ rtl/kmp_pkg.sv @@
// Shared types and constants for the KMP pattern matcher.
`default_nettype none
package kmp_pkg;

  localparam int BYTE_W = 8;
  localparam int POS_W  = 32;

  // Item kind codes
  localparam logic KIND_PATTERN = 1'b0;
  localparam logic KIND_TEXT    = 1'b1;

  // Sequencer states
  typedef enum logic [1:0] {
    S_IDLE,   // waiting for an item
    S_PAT,    // pattern byte at the current border is on the read port
    S_FAIL,   // failure entry for the fallback is on the read port
    S_MFAIL   // failure entry after a full match is on the read port
  } state_t;

endpackage
`default_nettype wire

@@ rtl/kmp_ram.sv @@
// Generic simple dual-port RAM with registered read.
`default_nettype none
module kmp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

@@ rtl/kmp_pattern_matcher.sv @@
// Streaming KMP matcher: pattern store, failure table build and text matching.
//
//   channel  direction  handshake            payload
//   in       sink       in_valid / in_stall  kind, byte_value, first
//   out      source     out_valid / out_stall match, end_position, pattern_overflow
//
// Steps: a byte whose pattern compare hits at once needs one pattern read; each
// failure-chain step adds a failure read, then a pattern read, on the registered
// RAM read; a full text match adds one failure read. A dropped pattern byte, a
// byte that starts a pattern, or a text byte with no pattern finishes as it is
// accepted. Chain steps and matches together average at most one per byte over
// a long text.
// Reset: synchronous; clears lengths, border, match length and position. The
// stores have no clearing pass; only entries below the pattern length are read.
// Stalls: the output register plus one hold register; input stalls while an
// item is in work or the hold register is full.
`default_nettype none
module kmp_pattern_matcher #(
  parameter int MAX_PATTERN = 1024
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic                       kind,
  input  wire logic [kmp_pkg::BYTE_W-1:0] byte_value,
  input  wire logic                       first,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic                            match,
  output logic      [kmp_pkg::POS_W-1:0]  end_position,
  output logic                            pattern_overflow
);

  localparam int AW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int LW = $clog2(MAX_PATTERN + 1);
  localparam logic [LW-1:0] MAX_LEN = LW'(MAX_PATTERN);

  // Control state
  kmp_pkg::state_t state, state_next;
  logic [LW-1:0] plen, plen_next;
  logic [LW-1:0] bp, bp_next;
  logic [LW-1:0] ml, ml_next;
  logic [kmp_pkg::POS_W-1:0] tpos, tpos_next;

  // Item in work
  logic [LW-1:0] k, k_next;
  logic item_kind, item_kind_next;
  logic [kmp_pkg::BYTE_W-1:0] item_c, item_c_next;
  logic [kmp_pkg::POS_W-1:0] item_pos, item_pos_next;

  // Result at finish
  logic fin, fin_match, fin_ovf;
  logic [kmp_pkg::POS_W-1:0] fin_pos;

  // Hold register behind the output
  logic pend_valid, pend_match, pend_ovf;
  logic [kmp_pkg::POS_W-1:0] pend_pos;

  // Memory ports
  logic pat_we, pat_re, fail_we, fail_re;
  logic [AW-1:0] pat_waddr, pat_raddr, fail_waddr, fail_raddr;
  logic [kmp_pkg::BYTE_W-1:0] pat_wdata, pat_rdata;
  logic [LW-1:0] fail_wdata, fail_rdata;

  logic accept, out_free;
  logic [LW-1:0] len_e, bp_e, ml_e, k_hit, k_fb;
  logic [kmp_pkg::POS_W-1:0] tpos_e;

  kmp_ram #(.WIDTH(kmp_pkg::BYTE_W), .DEPTH(MAX_PATTERN)) u_pat_ram (
    .clk(clk), .we(pat_we), .waddr(pat_waddr), .wdata(pat_wdata),
    .re(pat_re), .raddr(pat_raddr), .rdata(pat_rdata)
  );

  kmp_ram #(.WIDTH(LW), .DEPTH(MAX_PATTERN)) u_fail_ram (
    .clk(clk), .we(fail_we), .waddr(fail_waddr), .wdata(fail_wdata),
    .re(fail_re), .raddr(fail_raddr), .rdata(fail_rdata)
  );

  assign in_stall = !(state == kmp_pkg::S_IDLE && !pend_valid);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  // Next state, state updates and memory accesses
  always_comb begin
    state_next     = state;
    plen_next      = plen;
    bp_next        = bp;
    ml_next        = ml;
    tpos_next      = tpos;
    k_next         = k;
    item_kind_next = item_kind;
    item_c_next    = item_c;
    item_pos_next  = item_pos;
    fin            = 1'b0;
    fin_match      = 1'b0;
    fin_ovf        = 1'b0;
    fin_pos        = '0;
    pat_we         = 1'b0;
    pat_waddr      = '0;
    pat_wdata      = item_c;
    pat_re         = 1'b0;
    pat_raddr      = '0;
    fail_we        = 1'b0;
    fail_waddr     = '0;
    fail_wdata     = '0;
    fail_re        = 1'b0;
    fail_raddr     = '0;
    len_e          = first ? '0 : plen;
    bp_e           = first ? '0 : bp;
    ml_e           = first ? '0 : ml;
    tpos_e         = first ? '0 : tpos;
    k_hit          = k + LW'(1);
    k_fb           = (fail_rdata < k) ? fail_rdata : '0;

    case (state)
      kmp_pkg::S_IDLE: begin
        if (accept) begin
          item_kind_next = kind;
          item_c_next    = byte_value;
          if (kind == kmp_pkg::KIND_PATTERN) begin
            // pattern beat: optional restart, then append unless the store is full
            plen_next = len_e;
            bp_next   = bp_e;
            ml_next   = first ? '0 : ml;
            tpos_next = tpos_e;
            if (len_e >= MAX_LEN) begin
              fin     = 1'b1;
              fin_ovf = 1'b1;
            end else begin
              pat_we    = 1'b1;
              pat_waddr = len_e[AW-1:0];
              pat_wdata = byte_value;
              if (len_e == '0) begin
                fail_we    = 1'b1;
                fail_waddr = '0;
                fail_wdata = '0;
                bp_next    = '0;
                plen_next  = LW'(1);
                fin        = 1'b1;
              end else begin
                k_next     = (bp_e < len_e) ? bp_e : '0;
                pat_re     = 1'b1;
                pat_raddr  = ((bp_e < len_e) ? bp_e[AW-1:0] : '0);
                state_next = kmp_pkg::S_PAT;
              end
            end
          end else begin
            // text beat: optional restart, position advance
            ml_next       = ml_e;
            item_pos_next = tpos_e;
            tpos_next     = (tpos_e == '1) ? tpos_e : tpos_e + kmp_pkg::POS_W'(1);
            if (plen == '0) begin
              ml_next = '0;
              fin     = 1'b1;
              fin_pos = tpos_e;
            end else begin
              k_next     = (ml_e < plen) ? ml_e : '0;
              pat_re     = 1'b1;
              pat_raddr  = ((ml_e < plen) ? ml_e[AW-1:0] : '0);
              state_next = kmp_pkg::S_PAT;
            end
          end
        end
      end

      kmp_pkg::S_PAT: begin
        if (pat_rdata == item_c || k == '0) begin
          // chain ends: extend on a hit
          if (pat_rdata != item_c) begin
            k_hit = '0;
          end
          if (item_kind == kmp_pkg::KIND_PATTERN) begin
            fail_we    = 1'b1;
            fail_waddr = plen[AW-1:0];
            fail_wdata = k_hit;
            bp_next    = k_hit;
            plen_next  = plen + LW'(1);
            fin        = 1'b1;
            state_next = kmp_pkg::S_IDLE;
          end else if (k_hit >= plen) begin
            fail_re    = 1'b1;
            fail_raddr = AW'(plen - LW'(1));
            state_next = kmp_pkg::S_MFAIL;
          end else begin
            ml_next    = k_hit;
            fin        = 1'b1;
            fin_pos    = item_pos;
            state_next = kmp_pkg::S_IDLE;
          end
        end else begin
          fail_re    = 1'b1;
          fail_raddr = AW'(k - LW'(1));
          state_next = kmp_pkg::S_FAIL;
        end
      end

      kmp_pkg::S_FAIL: begin
        // fall back one border and fetch its pattern byte
        k_next     = k_fb;
        pat_re     = 1'b1;
        pat_raddr  = k_fb[AW-1:0];
        state_next = kmp_pkg::S_PAT;
      end

      kmp_pkg::S_MFAIL: begin
        // full match: resume from the border of the whole pattern
        ml_next    = (fail_rdata >= plen) ? '0 : fail_rdata;
        fin        = 1'b1;
        fin_match  = 1'b1;
        fin_pos    = item_pos;
        state_next = kmp_pkg::S_IDLE;
      end

      default: begin
        state_next = kmp_pkg::S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= kmp_pkg::S_IDLE;
      plen       <= '0;
      bp         <= '0;
      ml         <= '0;
      tpos       <= '0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      plen  <= plen_next;
      bp    <= bp_next;
      ml    <= ml_next;
      tpos  <= tpos_next;
      if (out_free) begin
        out_valid  <= fin || pend_valid;
        pend_valid <= 1'b0;
      end else if (fin) begin
        pend_valid <= 1'b1;
      end
    end
  end

  // Item and result payload
  always_ff @(posedge clk) begin
    k         <= k_next;
    item_kind <= item_kind_next;
    item_c    <= item_c_next;
    item_pos  <= item_pos_next;
    if (out_free) begin
      if (pend_valid) begin
        match            <= pend_match;
        end_position     <= pend_pos;
        pattern_overflow <= pend_ovf;
      end else begin
        match            <= fin_match;
        end_position     <= fin_pos;
        pattern_overflow <= fin_ovf;
      end
    end else if (fin) begin
      pend_match <= fin_match;
      pend_pos   <= fin_pos;
      pend_ovf   <= fin_ovf;
    end
  end

`ifndef NO_ASSERTIONS
  // hold register only fills behind a full output
  a_pend_behind_out: assert property (@(posedge clk) disable iff (rst)
    pend_valid |-> out_valid)
    else $error("hold register full while output empty");

  // no result is produced while an earlier one is still held
  a_fin_no_pend: assert property (@(posedge clk) disable iff (rst)
    fin |-> !pend_valid)
    else $error("result finished with hold register occupied");

  // pattern length never exceeds the store
  a_plen_bound: assert property (@(posedge clk) disable iff (rst)
    plen <= MAX_LEN)
    else $error("pattern length beyond store depth");

  // the border under compare always lies inside the written pattern
  a_k_in_pattern: assert property (@(posedge clk) disable iff (rst)
    (state == kmp_pkg::S_PAT || state == kmp_pkg::S_FAIL) |-> (k < plen))
    else $error("border reads beyond pattern length");
`endif

endmodule
`default_nettype wire

@@ test/tb_top.sv @@
// Self-checking testbench for the streaming KMP pattern matcher.
`timescale 1ns / 1ps
`default_nettype none
module tb_top;

  localparam int MAX_PAT     = 1024;
  localparam int CYCLE_LIMIT = 400000;
  localparam int ITEM_TARGET = 1650;

  // one expected result beat
  typedef struct {
    logic                      hit;
    logic [kmp_pkg::POS_W-1:0] end_pos;
    logic                      dropped;
  } kmp_result_t;

  // Predicts matcher results and checks the output stream against them
  class kmp_scoreboard;
    logic [kmp_pkg::BYTE_W-1:0] pat_mem [MAX_PAT];
    int unsigned                fail_mem [MAX_PAT];
    int unsigned                pat_len, border, run_len;
    logic [kmp_pkg::POS_W-1:0]  pos;
    kmp_result_t                pending [$];
    int errors, pattern_beats, text_beats, hit_count, dropped_beats, checked;

    function new();
      foreach (pat_mem[i]) begin
        pat_mem[i]  = '0;
        fail_mem[i] = 0;
      end
      pat_len = 0;
      border  = 0;
      run_len = 0;
      pos     = '0;
    endfunction

    // walk the failure chain from border k until byte c extends it or border zero is reached
    function int unsigned extend_border(int unsigned k, logic [kmp_pkg::BYTE_W-1:0] c);
      int unsigned n;
      while (k > 0 && pat_mem[k] != c) begin
        n = fail_mem[k-1];
        k = (n < k) ? n : 0;
      end
      if (pat_mem[k] == c) k++;
      return k;
    endfunction

    function void note_input(logic k, logic [kmp_pkg::BYTE_W-1:0] c, logic f);
      kmp_result_t r;
      int unsigned len, j;
      r.hit     = 1'b0;
      r.end_pos = '0;
      r.dropped = 1'b0;
      if (k == kmp_pkg::KIND_PATTERN) begin
        pattern_beats++;
        if (f) begin
          pat_len = 0;
          border  = 0;
          run_len = 0;
          pos     = '0;
        end
        if (pat_len >= MAX_PAT) begin
          r.dropped = 1'b1;
          dropped_beats++;
        end else begin
          len = pat_len;
          pat_mem[len] = c;
          if (len == 0) border = 0;
          else border = extend_border((border < len) ? border : 0, c);
          fail_mem[len] = border;
          pat_len = len + 1;
        end
      end else begin
        text_beats++;
        if (f) begin
          run_len = 0;
          pos     = '0;
        end
        r.end_pos = pos;
        if (pat_len > 0) begin
          j = (run_len < pat_len) ? run_len : 0;
          j = extend_border(j, c);
          if (j >= pat_len) begin
            // full occurrence: fall back so overlaps are still found
            r.hit = 1'b1;
            hit_count++;
            j = fail_mem[pat_len-1];
            if (j >= pat_len) j = 0;
          end
          run_len = j;
        end else begin
          run_len = 0;
        end
        if (pos != '1) pos++;
      end
      pending.push_back(r);
    endfunction

    function void check_result(logic hit, logic [kmp_pkg::POS_W-1:0] end_pos, logic dropped);
      kmp_result_t e;
      checked++;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("tb_top: unexpected result beat hit=%0b end=%0d drop=%0b",
                   hit, end_pos, dropped);
        return;
      end
      e = pending.pop_front();
      if (hit !== e.hit || end_pos !== e.end_pos || dropped !== e.dropped) begin
        errors++;
        if (errors <= 10)
          $display({"tb_top: mismatch at result %0d: exp hit=%0b end=%0d drop=%0b,",
                    " got hit=%0b end=%0d drop=%0b"},
                   checked, e.hit, e.end_pos, e.dropped, hit, end_pos, dropped);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic kind = 1'b0;
  logic [kmp_pkg::BYTE_W-1:0] byte_value = '0;
  logic first = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic hit;
  logic [kmp_pkg::POS_W-1:0] end_position;
  logic pattern_overflow;

  kmp_scoreboard sb;
  int cycle_count = 0;
  int burst_left = 0;
  int sent_count = 0;
  bit store_filled = 0;

  always #2 clk = ~clk;

  kmp_pattern_matcher #(.MAX_PATTERN(MAX_PAT)) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .kind(kind),
    .byte_value(byte_value),
    .first(first),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .match(hit),
    .end_position(end_position),
    .pattern_overflow(pattern_overflow)
  );

  // beat monitor on both channels, plus the run timeout
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_top: timeout after %0d cycles", cycle_count);
      $display("tb_top: done, errors");
      $finish;
    end else if (!rst) begin
      if (in_valid && !in_stall) sb.note_input(kind, byte_value, first);
      if (out_valid && !out_stall) sb.check_result(hit, end_position, pattern_overflow);
    end
  end

  // receiver backpressure from a randomly drawn stall mode
  int stall_mode = 0;
  int stall_run = 0;
  logic stall_level = 1'b0;
  always @(posedge clk) begin
    if (cycle_count % 256 == 0) stall_mode = $urandom_range(0, 3);
    case (stall_mode)
      0: stall_level = 1'b0;
      1: stall_level = ($urandom_range(0, 3) == 0);
      2: begin
        if (stall_run == 0) begin
          stall_level = ~stall_level;
          stall_run = $urandom_range(1, 12);
        end
        stall_run--;
      end
      default: stall_level = ~stall_level;
    endcase
    out_stall <= stall_level;
  end

  // present one beat and hold it until accepted; gaps fall between bursts
  task automatic send_item(input logic k, input logic [kmp_pkg::BYTE_W-1:0] b, input logic f);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : $urandom_range(0, 3);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 150)
                                               : $urandom_range(1, 24);
    end
    burst_left--;
    in_valid   <= 1'b1;
    kind       <= k;
    byte_value <= b;
    first      <= f;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent_count++;
  endtask

  // one pattern, then a text over the same small alphabet, with pattern growth and noise
  task automatic random_sequence();
    logic [kmp_pkg::BYTE_W-1:0] sym [3];
    logic [kmp_pkg::BYTE_W-1:0] pat [$];
    int nsym, plen, tlen, i, r;
    nsym = $urandom_range(1, 3);
    foreach (sym[s]) sym[s] = kmp_pkg::BYTE_W'($urandom_range(0, 255));
    if ($urandom_range(0, 7) == 0) begin
      sym[0] = 8'h00;
      sym[1] = 8'hFF;
    end
    plen = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 6) : $urandom_range(7, 40);
    for (i = 0; i < plen; i++) begin
      pat.push_back(sym[$urandom_range(0, nsym-1)]);
      send_item(kmp_pkg::KIND_PATTERN, pat[i], i == 0);
    end
    tlen = $urandom_range(4, 50);
    i = 0;
    while (i < tlen) begin
      r = $urandom_range(0, 99);
      if (r < 15) begin
        // plant a copy of the pattern
        foreach (pat[p]) send_item(kmp_pkg::KIND_TEXT, pat[p], (i == 0) && (p == 0));
        i += pat.size();
      end else if (r < 18 && i > 0) begin
        // pattern grows while the text runs on
        pat.push_back(sym[$urandom_range(0, nsym-1)]);
        send_item(kmp_pkg::KIND_PATTERN, pat[pat.size()-1], 1'b0);
      end else if (r < 20) begin
        send_item(kmp_pkg::KIND_TEXT, sym[$urandom_range(0, nsym-1)], 1'b1);
        i++;
      end else if (r < 25) begin
        send_item(kmp_pkg::KIND_TEXT, kmp_pkg::BYTE_W'($urandom_range(0, 255)), (i == 0));
        i++;
      end else begin
        send_item(kmp_pkg::KIND_TEXT, sym[$urandom_range(0, nsym-1)],
                  (i == 0) && ($urandom_range(0, 9) != 0));
        i++;
      end
    end
  endtask

  // fill the store to the limit with a near-periodic pattern, overflow it, then run text
  task automatic fill_store();
    logic [kmp_pkg::BYTE_W-1:0] a, b, c;
    int i, per;
    a = kmp_pkg::BYTE_W'($urandom_range(0, 255));
    b = a ^ 8'h01;
    per = $urandom_range(2, 6);
    for (i = 0; i < MAX_PAT; i++) begin
      c = ((i % per) == per - 1) ? b : a;
      if ($urandom_range(0, 199) == 0) c = kmp_pkg::BYTE_W'($urandom_range(0, 255));
      send_item(kmp_pkg::KIND_PATTERN, c, i == 0);
    end
    send_item(kmp_pkg::KIND_PATTERN, 8'h00, 1'b0);
    send_item(kmp_pkg::KIND_PATTERN, 8'hFF, 1'b0);
    send_item(kmp_pkg::KIND_PATTERN, kmp_pkg::BYTE_W'($urandom_range(0, 255)), 1'b0);
    for (i = 0; i < 80; i++) begin
      c = ((i % per) == per - 1) ? b : a;
      if ($urandom_range(0, 19) == 0) c = kmp_pkg::BYTE_W'($urandom_range(0, 255));
      send_item(kmp_pkg::KIND_TEXT, c, i == 0);
      if (i == 30 || i == 55) send_item(kmp_pkg::KIND_PATTERN, c, 1'b0);
    end
    store_filled = 1;
  endtask

  initial begin
    int n;
    sb = new();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty pattern: no match, position still counts
    send_item(kmp_pkg::KIND_TEXT, 8'h00, 1'b1);
    send_item(kmp_pkg::KIND_TEXT, 8'hFF, 1'b0);
    // pattern FF 00 FF and overlapping hits
    send_item(kmp_pkg::KIND_PATTERN, 8'hFF, 1'b1);
    send_item(kmp_pkg::KIND_PATTERN, 8'h00, 1'b0);
    send_item(kmp_pkg::KIND_PATTERN, 8'hFF, 1'b0);
    send_item(kmp_pkg::KIND_TEXT, 8'hFF, 1'b1);
    send_item(kmp_pkg::KIND_TEXT, 8'h00, 1'b0);
    send_item(kmp_pkg::KIND_TEXT, 8'hFF, 1'b0);
    send_item(kmp_pkg::KIND_TEXT, 8'h00, 1'b0);
    send_item(kmp_pkg::KIND_TEXT, 8'hFF, 1'b0);
    // pattern grows mid-text, matching continues
    send_item(kmp_pkg::KIND_PATTERN, 8'h00, 1'b0);
    send_item(kmp_pkg::KIND_TEXT, 8'h00, 1'b0);
    send_item(kmp_pkg::KIND_TEXT, 8'hFF, 1'b0);
    send_item(kmp_pkg::KIND_TEXT, 8'h00, 1'b0);
    // new text drops the partial match
    send_item(kmp_pkg::KIND_TEXT, 8'h00, 1'b1);
    send_item(kmp_pkg::KIND_TEXT, 8'hFF, 1'b0);
    // single-byte pattern hits on every matching byte
    send_item(kmp_pkg::KIND_PATTERN, 8'h5A, 1'b1);
    send_item(kmp_pkg::KIND_TEXT, 8'h5A, 1'b0);
    send_item(kmp_pkg::KIND_TEXT, 8'h5A, 1'b0);
    send_item(kmp_pkg::KIND_TEXT, 8'hA5, 1'b0);
    send_item(kmp_pkg::KIND_TEXT, 8'h5A, 1'b1);

    // random phase: mostly well-formed sequences, some noise, one full store
    while (sent_count < ITEM_TARGET) begin
      if (!store_filled && sent_count > 200) begin
        fill_store();
      end else if ($urandom_range(0, 9) == 0) begin
        n = $urandom_range(1, 5);
        repeat (n) send_item(1'($urandom_range(0, 1)),
                             kmp_pkg::BYTE_W'($urandom_range(0, 255)),
                             1'($urandom_range(0, 1)));
      end else begin
        random_sequence();
      end
    end
    in_valid <= 1'b0;

    // drain, then let any stray beat show up
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    sb.errors += sb.pending.size();

    $display("tb_top: %0d pattern beats (%0d dropped), %0d text beats, %0d matches",
             sb.pattern_beats, sb.dropped_beats, sb.text_beats, sb.hit_count);
    $display("tb_top: %0d result beats checked, %0d failures, %0d cycles",
             sb.checked, sb.errors, cycle_count);
    if (sb.errors == 0)
      $display("tb_top: done, clean");
    else
      $display("tb_top: done, errors");
    $finish;
  end

endmodule
`default_nettype wire
